### src/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Types, widths and constants of the battery voltage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package bvm_pkg;

	// defaults of the top-level parameters
	localparam int SAMPLES_DEF  = 16;
	localparam int LOW_TRIP_DEF = 5;

	// field and state widths
	localparam int SMP_W   = 12;
	localparam int SUM_W   = 16;
	localparam int IDX_W   = 4;
	localparam int VOLT_W  = 9;
	localparam int BAR_W   = 5;
	localparam int LCNT_W  = 3;
	localparam int RATIO_W = 11;

	// serial arithmetic widths
	localparam int NUM_W  = 27;
	localparam int DEN_W  = 14;
	localparam int MUL_AW = 12;
	localparam int MUL_BW = 16;
	localparam int PROD_W = MUL_AW + MUL_BW;

	// arithmetic constants
	localparam logic [MUL_BW-1:0]  K_RATIO_SCALE = 16'd1000;
	localparam logic [MUL_BW-1:0]  K_VOLT_GAIN   = 16'd61348;
	localparam logic [MUL_BW-1:0]  K_BAR_SCALE   = 16'd27;
	localparam logic [DEN_W-1:0]   K_GAIN_DIV    = 14'd10000;
	localparam logic [DEN_W-1:0]   K_TEN         = 14'd10;
	localparam logic [DEN_W-1:0]   K_OFFSET      = 14'd3061;
	localparam logic [VOLT_W-1:0]  VOLT_MAX      = 9'd500;
	localparam logic [BAR_W-1:0]   BAR_FULL      = 5'd27;
	// any ratio at or above this already saturates the voltage
	localparam logic [RATIO_W-1:0] RATIO_MAX     = 11'd2047;

	// register reset values
	localparam logic [VOLT_W-1:0] LOW_RST  = 9'd330;
	localparam logic [VOLT_W-1:0] HIGH_RST = 9'd420;

	typedef enum logic [0:0] {
		REG_LOW_THRESHOLD  = 1'b0,
		REG_HIGH_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_AVGB,
		ST_AVGR,
		ST_MULR,
		ST_DIVR,
		ST_MULS,
		ST_DIVS,
		ST_DIVV,
		ST_BAR,
		ST_MULB,
		ST_DIVB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [SMP_W-1:0] battery_sample;
		logic [SMP_W-1:0] reference_sample;
	} sample_t;

	typedef struct packed {
		logic [VOLT_W-1:0] voltage;
		logic [BAR_W-1:0]  bar_level;
		logic              below_min;
		logic [LCNT_W-1:0] low_count;
		logic              power_down;
	} result_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

### src/bvm_stream_if.sv
// ----------------------------------------------------------------------------
// bvm_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// Averages battery/reference sample pairs, converts to hundredths of a volt,
// derives a bar level and trips a power-down flag on repeated low readings.
// ----------------------------------------------------------------------------
//
//   channel   dir  payload                                          handshake
//   samples   in   battery_sample, reference_sample                 valid/ready
//   results   out  voltage, bar_level, below_min, low_count,        valid/ready
//                  power_down
//   cfg       in   cfg_index, cfg_wdata                             cfg_wr_en
//
// Sample pairs are taken one per cycle while no conversion runs. The SAMPLES-th
// pair starts the conversion: up to six divides on the bit-serial divider and
// up to three products on the bit-serial multiplier; no pair is taken
// meanwhile. The result waits in an output register; a stalled result holds
// the block only when the next conversion is done. Reset clears the sums,
// counters and latch and sets the thresholds to 330 / 420.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_monitor #(
	parameter int SAMPLES        = bvm_pkg::SAMPLES_DEF,
	parameter int LOW_TRIP_COUNT = bvm_pkg::LOW_TRIP_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bvm_stream_if.sink                        samples,
	bvm_stream_if.source                      results,
	input  wire logic                         cfg_wr_en,
	input  wire logic [0:0]                   cfg_index,
	input  wire logic [bvm_pkg::VOLT_W-1:0]   cfg_wdata
);
	localparam logic [bvm_pkg::IDX_W-1:0]  SAMPLES_MOD = bvm_pkg::IDX_W'(SAMPLES);
	localparam logic [bvm_pkg::DEN_W-1:0]  SAMPLES_DEN = bvm_pkg::DEN_W'(SAMPLES);
	localparam logic [bvm_pkg::LCNT_W-1:0] TRIP_CNT    = bvm_pkg::LCNT_W'(LOW_TRIP_COUNT);

	bvm_pkg::state_t state_q, state_n;

	logic [bvm_pkg::SUM_W-1:0]   bsum_q, rsum_q;
	logic [bvm_pkg::IDX_W-1:0]   idx_q;
	logic [bvm_pkg::LCNT_W-1:0]  low_cnt_q;
	logic                        shut_q;
	logic [bvm_pkg::VOLT_W-1:0]  lo_q, hi_q;
	logic                        launched_q;
	logic                        out_valid_q;
	bvm_pkg::result_t            result_q;

	logic [bvm_pkg::SMP_W-1:0]   avg_bat_q, avg_ref_q;
	logic [bvm_pkg::RATIO_W-1:0] ratio_q;
	logic [bvm_pkg::NUM_W-1:0]   num_q;
	logic [bvm_pkg::VOLT_W-1:0]  volt_q;
	logic [bvm_pkg::BAR_W-1:0]   bar_q;

	logic                        in_req;
	logic                        last_pair;
	logic [bvm_pkg::IDX_W-1:0]   idx_n;
	logic [bvm_pkg::SUM_W-1:0]   bsum_n, rsum_n;
	logic                        load_out;
	logic                        below;
	logic [bvm_pkg::LCNT_W-1:0]  low_cnt_n;
	logic [bvm_pkg::VOLT_W-1:0]  t_hi, t_clamp;

	logic                        div_start, mul_start;
	logic [bvm_pkg::NUM_W-1:0]   div_num;
	logic [bvm_pkg::DEN_W-1:0]   div_den;
	logic [bvm_pkg::NUM_W-1:0]   div_quo;
	bvm_pkg::unit_stat_t         div_stat;
	logic [bvm_pkg::MUL_AW-1:0]  mul_a;
	logic [bvm_pkg::MUL_BW-1:0]  mul_b;
	logic [bvm_pkg::PROD_W-1:0]  mul_prod;
	bvm_pkg::unit_stat_t         mul_stat;

	bvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	bvm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	// accumulation, low-count and threshold clamp arithmetic
	always_comb begin
		in_req    = samples.valid && samples.ready;
		idx_n     = idx_q + 1'b1;
		last_pair = (idx_n == SAMPLES_MOD);
		bsum_n    = bsum_q + bvm_pkg::SUM_W'(samples.data.battery_sample);
		rsum_n    = rsum_q + bvm_pkg::SUM_W'(samples.data.reference_sample);
		below     = !shut_q && (volt_q < lo_q);
		low_cnt_n = low_cnt_q + bvm_pkg::LCNT_W'(below);
		t_hi      = (volt_q > hi_q) ? hi_q : volt_q;
		t_clamp   = (t_hi < lo_q) ? lo_q : t_hi;
	end

	// next state and unit operands
	always_comb begin
		state_n       = state_q;
		samples.ready = 1'b0;
		div_start     = 1'b0;
		mul_start     = 1'b0;
		div_num       = num_q;
		div_den       = bvm_pkg::K_TEN;
		mul_a         = avg_bat_q;
		mul_b         = bvm_pkg::K_RATIO_SCALE;
		load_out      = 1'b0;
		unique case (state_q)
			bvm_pkg::ST_ACC: begin
				samples.ready = 1'b1;
				if (in_req && last_pair) begin
					state_n = bvm_pkg::ST_AVGB;
				end
			end
			bvm_pkg::ST_AVGB: begin
				div_start = !launched_q;
				div_num   = bvm_pkg::NUM_W'(bsum_q);
				div_den   = SAMPLES_DEN;
				if (div_stat.done) begin
					state_n = bvm_pkg::ST_AVGR;
				end
			end
			bvm_pkg::ST_AVGR: begin
				div_start = !launched_q;
				div_num   = bvm_pkg::NUM_W'(rsum_q);
				div_den   = SAMPLES_DEN;
				if (div_stat.done) begin
					state_n = (div_quo == '0) ? bvm_pkg::ST_BAR : bvm_pkg::ST_MULR;
				end
			end
			bvm_pkg::ST_MULR: begin
				mul_start = !launched_q;
				if (mul_stat.done) begin
					state_n = bvm_pkg::ST_DIVR;
				end
			end
			bvm_pkg::ST_DIVR: begin
				div_start = !launched_q;
				div_den   = bvm_pkg::DEN_W'(avg_ref_q);
				if (div_stat.done) begin
					state_n = bvm_pkg::ST_MULS;
				end
			end
			bvm_pkg::ST_MULS: begin
				mul_start = !launched_q;
				mul_a     = bvm_pkg::MUL_AW'(ratio_q);
				mul_b     = bvm_pkg::K_VOLT_GAIN;
				if (mul_stat.done) begin
					state_n = bvm_pkg::ST_DIVS;
				end
			end
			bvm_pkg::ST_DIVS: begin
				div_start = !launched_q;
				div_den   = bvm_pkg::K_GAIN_DIV;
				if (div_stat.done) begin
					state_n = (div_quo < bvm_pkg::NUM_W'(bvm_pkg::K_OFFSET)) ?
						bvm_pkg::ST_BAR : bvm_pkg::ST_DIVV;
				end
			end
			bvm_pkg::ST_DIVV: begin
				div_start = !launched_q;
				div_den   = bvm_pkg::K_TEN;
				if (div_stat.done) begin
					state_n = bvm_pkg::ST_BAR;
				end
			end
			bvm_pkg::ST_BAR: begin
				state_n = (hi_q <= lo_q) ? bvm_pkg::ST_OUT : bvm_pkg::ST_MULB;
			end
			bvm_pkg::ST_MULB: begin
				mul_start = !launched_q;
				mul_a     = bvm_pkg::MUL_AW'(num_q[bvm_pkg::VOLT_W-1:0]);
				mul_b     = bvm_pkg::K_BAR_SCALE;
				if (mul_stat.done) begin
					state_n = bvm_pkg::ST_DIVB;
				end
			end
			bvm_pkg::ST_DIVB: begin
				div_start = !launched_q;
				div_den   = bvm_pkg::DEN_W'(hi_q - lo_q);
				if (div_stat.done) begin
					state_n = bvm_pkg::ST_OUT;
				end
			end
			bvm_pkg::ST_OUT: begin
				if (!out_valid_q || results.ready) begin
					load_out = 1'b1;
					state_n  = bvm_pkg::ST_ACC;
				end
			end
			default: begin
				state_n = bvm_pkg::ST_ACC;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvm_pkg::ST_ACC;
		end else begin
			state_q <= state_n;
		end
	end

	// control state: sums, counters, latch, thresholds, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsum_q      <= '0;
			rsum_q      <= '0;
			idx_q       <= '0;
			low_cnt_q   <= '0;
			shut_q      <= 1'b0;
			lo_q        <= bvm_pkg::LOW_RST;
			hi_q        <= bvm_pkg::HIGH_RST;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// accept a sample pair
			if (in_req) begin
				bsum_q <= bsum_n;
				rsum_q <= rsum_n;
				idx_q  <= last_pair ? '0 : idx_n;
			end

			// one request per arithmetic step
			if (div_start || mul_start) begin
				launched_q <= 1'b1;
			end else if (div_stat.done || mul_stat.done) begin
				launched_q <= 1'b0;
			end

			// register writes
			if (cfg_wr_en) begin
				unique case (bvm_pkg::reg_idx_t'(cfg_index))
					bvm_pkg::REG_LOW_THRESHOLD:  lo_q <= cfg_wdata;
					bvm_pkg::REG_HIGH_THRESHOLD: hi_q <= cfg_wdata;
					default: ;
				endcase
			end

			// output register and low-battery tracking
			if (load_out) begin
				out_valid_q <= 1'b1;
				bsum_q      <= '0;
				rsum_q      <= '0;
				if (!shut_q) begin
					low_cnt_q <= low_cnt_n;
					if (low_cnt_n == TRIP_CNT) begin
						shut_q <= 1'b1;
					end
				end
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			bvm_pkg::ST_AVGB: begin
				if (div_stat.done) avg_bat_q <= div_quo[bvm_pkg::SMP_W-1:0];
			end
			bvm_pkg::ST_AVGR: begin
				if (div_stat.done) begin
					avg_ref_q <= div_quo[bvm_pkg::SMP_W-1:0];
					volt_q    <= bvm_pkg::VOLT_MAX;
				end
			end
			bvm_pkg::ST_MULR, bvm_pkg::ST_MULS, bvm_pkg::ST_MULB: begin
				if (mul_stat.done) num_q <= mul_prod[bvm_pkg::NUM_W-1:0];
			end
			bvm_pkg::ST_DIVR: begin
				if (div_stat.done) begin
					ratio_q <= (div_quo > bvm_pkg::NUM_W'(bvm_pkg::RATIO_MAX)) ?
						bvm_pkg::RATIO_MAX : div_quo[bvm_pkg::RATIO_W-1:0];
				end
			end
			bvm_pkg::ST_DIVS: begin
				if (div_stat.done) begin
					num_q  <= div_quo - bvm_pkg::NUM_W'(bvm_pkg::K_OFFSET);
					volt_q <= '0;
				end
			end
			bvm_pkg::ST_DIVV: begin
				if (div_stat.done) begin
					volt_q <= (div_quo > bvm_pkg::NUM_W'(bvm_pkg::VOLT_MAX)) ?
						bvm_pkg::VOLT_MAX : div_quo[bvm_pkg::VOLT_W-1:0];
				end
			end
			bvm_pkg::ST_BAR: begin
				bar_q <= '0;
				num_q <= bvm_pkg::NUM_W'(t_clamp - lo_q);
			end
			bvm_pkg::ST_DIVB: begin
				if (div_stat.done) begin
					bar_q <= bvm_pkg::BAR_FULL - div_quo[bvm_pkg::BAR_W-1:0];
				end
			end
			bvm_pkg::ST_OUT: begin
				if (load_out) begin
					result_q.voltage    <= volt_q;
					result_q.bar_level  <= bar_q;
					result_q.below_min  <= below;
					result_q.low_count  <= shut_q ? low_cnt_q : low_cnt_n;
					result_q.power_down <= shut_q || (low_cnt_n == TRIP_CNT);
				end
			end
			default: ;
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.data  = result_q;

	// the power-down latch never releases
	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		shut_q |=> shut_q)
		else $error("power-down latch released");

	// a new result is only loaded from the output step
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == bvm_pkg::ST_OUT))
		else $error("result loaded outside output step");

	// no arithmetic request while a unit is still working
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(div_start || mul_start) |-> (!div_stat.busy && !mul_stat.busy))
		else $error("arithmetic request while unit busy");

	// samples are taken only between conversions
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> (!div_stat.busy && !mul_stat.busy && !launched_q))
		else $error("sample request during conversion");
endmodule

`default_nettype wire

### src/bvm_div.sv
// ----------------------------------------------------------------------------
// bvm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bvm_pkg::NUM_W-1:0]  num,
	input  wire logic [bvm_pkg::DEN_W-1:0]  den,
	output bvm_pkg::unit_stat_t             stat,
	output logic      [bvm_pkg::NUM_W-1:0]  quo
);
	localparam int CW = $clog2(bvm_pkg::NUM_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [bvm_pkg::NUM_W-1:0]   quo_q;
	logic [bvm_pkg::DEN_W-1:0]   rem_q;

	logic [bvm_pkg::DEN_W:0]     trial;
	logic [bvm_pkg::DEN_W:0]     diff;
	logic                        fits;

	// one restoring step: bring down the next bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[bvm_pkg::NUM_W-1]};
		diff  = trial - {1'b0, den};
		fits  = (trial >= {1'b0, den});
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(bvm_pkg::NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[bvm_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? diff[bvm_pkg::DEN_W-1:0] : trial[bvm_pkg::DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;
endmodule

`default_nettype wire

### src/bvm_mul.sv
// ----------------------------------------------------------------------------
// bvm_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bvm_pkg::MUL_AW-1:0]  a,
	input  wire logic [bvm_pkg::MUL_BW-1:0]  b,
	output bvm_pkg::unit_stat_t              stat,
	output logic      [bvm_pkg::PROD_W-1:0]  prod
);
	localparam int CW = $clog2(bvm_pkg::MUL_BW);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [bvm_pkg::PROD_W-1:0]  mcand_q;
	logic [bvm_pkg::MUL_BW-1:0]  mplier_q;
	logic [bvm_pkg::PROD_W-1:0]  acc_q;

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(bvm_pkg::MUL_BW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// multiplier bits shift out low first, multiplicand shifts up
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= bvm_pkg::PROD_W'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			mcand_q  <= {mcand_q[bvm_pkg::PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[bvm_pkg::MUL_BW-1:1]};
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;
endmodule

`default_nettype wire
